@@ src/assert_macros.svh @@
// Assertion macros shared by the key event detector modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define KED_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define KED_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ked_pkg.sv @@
// Types and constants of the key event detector.
package ked_pkg;

    localparam int LEVELS_W   = 5;
    localparam int INDEX_W    = 3;
    localparam int FLAG_W     = 7;
    localparam int TIMER_W    = 16;
    localparam int PERIOD_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FLAG_DOWN   = 0;
    localparam int FLAG_UP     = 1;
    localparam int FLAG_HOLD   = 2;
    localparam int FLAG_SINGLE = 3;
    localparam int FLAG_DOUBLE = 4;
    localparam int FLAG_LONG   = 5;
    localparam int FLAG_REPEAT = 6;

    localparam logic [FLAG_W-1:0] HOLD_MASK = FLAG_W'(1 << FLAG_HOLD);

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_EN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DBL_WINDOW = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT     = 3'd4;

    localparam logic [PERIOD_W-1:0] RST_DEBOUNCE   = 8'd20;
    localparam logic [TIMER_W-1:0]  RST_DBL_WINDOW = 16'd300;
    localparam logic [TIMER_W-1:0]  RST_LONG_TIME  = 16'd1600;
    localparam logic [TIMER_W-1:0]  RST_REPEAT     = 16'd100;

    typedef struct packed {
        logic               double_en;
        logic [TIMER_W-1:0] double_window;
        logic [TIMER_W-1:0] long_time;
        logic [TIMER_W-1:0] repeat_ivl;
    } t_cfg;

    typedef struct packed {
        logic              tick;
        logic              sample;
        logic              check;
        logic [FLAG_W-1:0] mask;
    } t_key_ctl;

endpackage

@@ src/key_event_detector_unit.sv @@
// Top level of the multi-key click, long press and repeat event detector.
//
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-------------------------------------------------
//  request  | i_valid  | o_stall  | i_command, i_key_levels, i_key_index, i_flag_mask
//  result   | o_valid  | i_stall  | o_hit
//  config   | i_cfg_wr_en (no stall) | i_cfg_index, i_cfg_data
//
//  One request per cycle while o_stall is low; an accepted request loads the request
//  register, then the result register once that is empty or not stalled, setting o_valid.
//  All keys are updated side by side as the request moves into the result register.
//  Request register and result register form a two-deep pipe, so a new request
//  is taken while a finished result waits.
//  Synchronous active-low reset clears all key state and loads the register defaults.
//  A stalled result holds o_valid and o_hit; o_stall rises only when both stages are full.
`include "assert_macros.svh"

module key_event_detector_unit #(
    parameter int KEYS = 5
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_command,
    input  logic [ked_pkg::LEVELS_W-1:0]    i_key_levels,
    input  logic [ked_pkg::INDEX_W-1:0]     i_key_index,
    input  logic [ked_pkg::FLAG_W-1:0]      i_flag_mask,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_hit,
    input  logic                            i_cfg_wr_en,
    input  logic [ked_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ked_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ked_pkg::*;

    logic                r_in_vld;
    logic                r_cmd;
    logic [LEVELS_W-1:0] r_levels;
    logic [INDEX_W-1:0]  r_index;
    logic [FLAG_W-1:0]   r_mask;
    logic                r_out_vld;
    logic                r_hit;

    logic [PERIOD_W-1:0] r_debounce;
    t_cfg                r_cfg;
    logic [PERIOD_W-1:0] r_tick_count;
    logic [PERIOD_W-1:0] n_tick_count;

    logic                w_adv;
    logic                w_go;
    logic                w_sample;
    t_key_ctl            w_ctl;
    logic [KEYS-1:0]     w_hits;

    assign w_adv   = !r_out_vld || !i_stall;
    assign w_go    = r_in_vld && w_adv;
    assign o_stall = r_in_vld && !w_adv;
    assign o_valid = r_out_vld;
    assign o_hit   = r_hit;

    assign n_tick_count = r_tick_count + PERIOD_W'(1);
    assign w_sample     = n_tick_count >= r_debounce;

    assign w_ctl.tick   = w_go && !r_cmd;
    assign w_ctl.sample = w_sample;
    assign w_ctl.check  = w_go && r_cmd;
    assign w_ctl.mask   = r_mask;

    for (genvar K = 0; K < KEYS; K++) begin : g_key
        logic w_level;
        logic w_sel;
        if (K < LEVELS_W) begin : g_lvl
            assign w_level = r_levels[K];
        end else begin : g_nolvl
            assign w_level = 1'b0;
        end
        assign w_sel = int'(r_index) == K;
        ked_key u_key (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_cfg     (r_cfg),
            .i_sel     (w_sel),
            .i_pressed (!w_level),
            .o_hit     (w_hits[K])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_tick_count <= '0;
        end else begin
            r_in_vld  <= (i_valid && !o_stall) || (r_in_vld && !w_adv);
            r_out_vld <= w_go || (r_out_vld && i_stall);
            if (w_ctl.tick) begin
                r_tick_count <= w_sample ? '0 : n_tick_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd    <= i_command;
            r_levels <= i_key_levels;
            r_index  <= i_key_index;
            r_mask   <= i_flag_mask;
        end
        if (w_go) begin
            r_hit <= |w_hits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce          <= RST_DEBOUNCE;
            r_cfg.double_en     <= 1'b0;
            r_cfg.double_window <= RST_DBL_WINDOW;
            r_cfg.long_time     <= RST_LONG_TIME;
            r_cfg.repeat_ivl    <= RST_REPEAT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:   r_debounce          <= i_cfg_data[PERIOD_W-1:0];
                CFG_DOUBLE_EN:  r_cfg.double_en     <= i_cfg_data[0];
                CFG_DBL_WINDOW: r_cfg.double_window <= i_cfg_data[TIMER_W-1:0];
                CFG_LONG_TIME:  r_cfg.long_time     <= i_cfg_data[TIMER_W-1:0];
                CFG_REPEAT:     r_cfg.repeat_ivl    <= i_cfg_data[TIMER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    `KED_ASSERT_IMP(a_stall_needs_request, o_stall, r_in_vld && r_out_vld, "stall, pipe not full")
    `KED_ASSERT_NXT(a_go_fills_result, w_go, r_out_vld, "advanced request left no result")
    `KED_ASSERT_NXT(a_sample_clears_count, w_ctl.tick && w_sample, r_tick_count == '0, "count kept")

endmodule

@@ src/ked_key.sv @@
// Per-key timer, click state machine and sticky event flags.
`include "assert_macros.svh"

module ked_key (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ked_pkg::t_key_ctl i_ctl,
    input  ked_pkg::t_cfg     i_cfg,
    input  logic              i_sel,
    input  logic              i_pressed,
    output logic              o_hit
);
    import ked_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE     = 3'd0,
        S_PRESSED  = 3'd1,
        S_DBL_WAIT = 3'd2,
        S_SECOND   = 3'd3,
        S_REPEAT   = 3'd4
    } t_click;

    t_click             r_state, n_state;
    logic               r_cur, n_cur;
    logic [TIMER_W-1:0] r_timer, n_timer;
    logic [FLAG_W-1:0]  r_flags, n_flags;
    logic [TIMER_W-1:0] w_dec;

    assign w_dec = (r_timer != '0) ? r_timer - TIMER_W'(1) : r_timer;
    assign o_hit = i_ctl.check && i_sel && (|(r_flags & i_ctl.mask));

    always_comb begin
        n_state = r_state;
        n_cur   = r_cur;
        n_timer = r_timer;
        n_flags = r_flags;
        if (i_ctl.tick) begin
            n_timer = w_dec;
            if (i_ctl.sample) begin
                n_cur              = i_pressed;
                n_flags[FLAG_HOLD] = i_pressed;
                if (i_pressed && !r_cur) begin
                    n_flags[FLAG_DOWN] = 1'b1;
                end
                if (!i_pressed && r_cur) begin
                    n_flags[FLAG_UP] = 1'b1;
                end
                unique case (r_state)
                    S_PRESSED: begin
                        if (!i_pressed) begin
                            if (i_cfg.double_en) begin
                                n_timer = i_cfg.double_window;
                                n_state = S_DBL_WAIT;
                            end else begin
                                n_flags[FLAG_SINGLE] = 1'b1;
                                n_state              = S_IDLE;
                            end
                        end else if (w_dec == '0) begin
                            n_timer            = i_cfg.repeat_ivl;
                            n_flags[FLAG_LONG] = 1'b1;
                            n_state            = S_REPEAT;
                        end
                    end
                    S_DBL_WAIT: begin
                        if (i_pressed) begin
                            n_flags[FLAG_DOUBLE] = 1'b1;
                            n_state              = S_SECOND;
                        end else if (w_dec == '0) begin
                            n_flags[FLAG_SINGLE] = 1'b1;
                            n_state              = S_IDLE;
                        end
                    end
                    S_SECOND: begin
                        if (!i_pressed) begin
                            n_state = S_IDLE;
                        end
                    end
                    S_REPEAT: begin
                        if (!i_pressed) begin
                            n_state = S_IDLE;
                        end else if (w_dec == '0) begin
                            n_timer              = i_cfg.repeat_ivl;
                            n_flags[FLAG_REPEAT] = 1'b1;
                        end
                    end
                    default: begin
                        if (i_pressed) begin
                            n_timer = i_cfg.long_time;
                            n_state = S_PRESSED;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
        end
        if (i_ctl.check && i_sel && (i_ctl.mask != HOLD_MASK)) begin
            n_flags = r_flags & ~i_ctl.mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= 1'b0;
            r_timer <= '0;
            r_flags <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_timer <= n_timer;
            r_flags <= n_flags;
        end
    end

    `KED_ASSERT_IMP(a_held_states_pressed, r_state == S_PRESSED || r_state == S_SECOND || r_state == S_REPEAT, r_cur, "held state without pressed key")
    `KED_ASSERT_IMP(a_dbl_wait_released, r_state == S_DBL_WAIT, !r_cur, "double window with key pressed")
    `KED_ASSERT_NXT(a_timer_no_rise, !(i_ctl.tick && i_ctl.sample), r_timer <= $past(r_timer), "timer rose without a sample")

endmodule
